// ===== hw/rtl/rotated_bitmap_sprite_plotter_top_defines.svh =====
// Assertion macros shared by the checker of the sprite plotter.
`ifndef ROTATED_BITMAP_SPRITE_PLOTTER_TOP_DEFINES_SVH
`define ROTATED_BITMAP_SPRITE_PLOTTER_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is high.
`define RBSP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define RBSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define RBSP_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rbsp_pkg.sv =====
package rbsp_pkg;

   localparam int SPRITE_ROWS_DEF   = 20;
   localparam int BYTES_PER_ROW_DEF = 3;
   localparam int LANES             = 8;
   localparam int CENTRE_OFFSET     = 10;
   localparam logic [15:0] PIXEL_COLOR = 16'hFFFF;

   // register indexes on the CSR port
   localparam logic [2:0] REG_ANGLE_X  = 3'd0;
   localparam logic [2:0] REG_ANGLE_Y  = 3'd1;
   localparam logic [2:0] REG_ANGLE_Z  = 3'd2;
   localparam logic [2:0] REG_ORIGIN_X = 3'd3;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd4;
   localparam logic [2:0] REG_WIDTH    = 3'd5;
   localparam logic [2:0] REG_HEIGHT   = 3'd6;
   localparam logic [2:0] REG_PITCH    = 3'd7;

   typedef struct packed {
      logic signed [17:0] c0;
      logic signed [17:0] c1;
      logic signed [17:0] c2;
      logic signed [17:0] c3;
   } coef_type;

   typedef struct packed {
      logic        hit;
      logic [11:0] x;
      logic [11:0] y;
      logic [23:0] off;
   } lane_res_type;

   typedef logic [15:0] qsine_tab_type [0:1024];

   // Quarter-wave sine in Q1.15, odd series of sin(pi/2*t) to t^9.
   function automatic logic [15:0] quarter_sine(int idx);
      longint unsigned t, t2, p, s;
      t  = longint'(idx & 2047) << 20;
      t2 = (t * t) >> 30;
      p  = 64'd172272;
      p  = 64'd5026996    - ((p * t2) >> 30);
      p  = 64'd85569306   - ((p * t2) >> 30);
      p  = 64'd693598668  - ((p * t2) >> 30);
      p  = 64'd1686629713 - ((p * t2) >> 30);
      s  = (p * t) >> 30;
      s  = (s + 64'd16384) >> 15;
      if (s > 64'd32768) begin
         s = 64'd32768;
      end
      return s[15:0];
   endfunction

   function automatic qsine_tab_type build_qsine();
      qsine_tab_type tab;
      for (int i = 0; i <= 1024; i++) begin
         tab[i] = quarter_sine(i);
      end
      return tab;
   endfunction

   localparam qsine_tab_type QSINE = build_qsine();

endpackage

// ===== hw/rtl/rbsp_coef.sv =====
module rbsp_coef (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [11:0]       angle_x,
   input  logic [11:0]       angle_y,
   input  logic [11:0]       angle_z,
   output rbsp_pkg::coef_type coef,
   output logic              busy
);
   import rbsp_pkg::*;

   typedef enum logic [1:0] {IDLE, FETCH, MUL} state_type;
   typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_type;
   typedef enum logic [2:0] {DST_NONE, DST_T, DST_C0, DST_C1, DST_C2, DST_C3} dst_type;

   state_type          state_ff;
   logic [2:0]         cnt_ff;
   logic [15:0]        rom_ff;
   logic               neg_ff, rv_ff;
   logic [2:0]         slot_ff;
   logic signed [17:0] sx_ff, cx_ff, sy_ff, cy_ff, sz_ff, cz_ff, t_ff;
   logic signed [36:0] acc_ff, acc_in;
   dst_type            dst_ff, dst_in;
   coef_type           coef_ff;

   logic [11:0]        ang;
   logic [10:0]        ridx;
   logic signed [17:0] sval;
   logic signed [17:0] op_a, op_b;
   logic signed [35:0] prod;
   acc_op_type         aop;
   logic signed [21:0] rnd;
   logic signed [17:0] sat;

   always_comb begin
      case (cnt_ff)
         3'd0:    ang = angle_x;
         3'd1:    ang = angle_x + 12'd1024;
         3'd2:    ang = angle_y;
         3'd3:    ang = angle_y + 12'd1024;
         3'd4:    ang = angle_z;
         3'd5:    ang = angle_z + 12'd1024;
         default: ang = angle_x;
      endcase
      ridx = ang[10] ? (11'd1024 - {1'b0, ang[9:0]}) : {1'b0, ang[9:0]};
   end

   assign sval = neg_ff ? -$signed({2'b00, rom_ff}) : $signed({2'b00, rom_ff});

   always_comb begin
      op_a   = sx_ff;
      op_b   = sy_ff;
      aop    = ACC_LOAD;
      dst_in = DST_NONE;
      case (cnt_ff)
         3'd0: begin op_a = sx_ff; op_b = sy_ff; dst_in = DST_T; end
         3'd1: begin op_a = cy_ff; op_b = cz_ff; dst_in = DST_C0; end
         3'd2: begin op_a = cy_ff; op_b = sz_ff; dst_in = DST_C1; end
         3'd3: begin op_a = t_ff;  op_b = cz_ff; end
         3'd4: begin op_a = cx_ff; op_b = sz_ff; aop = ACC_SUB; dst_in = DST_C2; end
         3'd5: begin op_a = t_ff;  op_b = sz_ff; end
         3'd6: begin op_a = cx_ff; op_b = cz_ff; aop = ACC_ADD; dst_in = DST_C3; end
         default: begin aop = ACC_LOAD; end
      endcase
      if (state_ff != MUL || cnt_ff == 3'd7) begin
         dst_in = DST_NONE;
      end
      prod = op_a * op_b;
      case (aop)
         ACC_ADD: acc_in = acc_ff + 37'(prod);
         ACC_SUB: acc_in = acc_ff - 37'(prod);
         default: acc_in = 37'(prod);
      endcase
   end

   // round half up from Q30 to Q15, then clamp to 18 bits
   always_comb begin
      rnd = 22'((acc_ff + 37'sd16384) >>> 15);
      if (rnd > 22'sd131071) begin
         sat = 18'sd131071;
      end else if (rnd < -22'sd131072) begin
         sat = -18'sd131072;
      end else begin
         sat = rnd[17:0];
      end
   end

   always_ff @(posedge clock) begin
      rom_ff  <= QSINE[ridx];
      neg_ff  <= ang[11];
      slot_ff <= cnt_ff;
      acc_ff  <= acc_in;
      if (rv_ff) begin
         case (slot_ff)
            3'd0:    sx_ff <= sval;
            3'd1:    cx_ff <= sval;
            3'd2:    sy_ff <= sval;
            3'd3:    cy_ff <= sval;
            3'd4:    sz_ff <= sval;
            default: cz_ff <= sval;
         endcase
      end
      case (dst_ff)
         DST_T:   t_ff       <= sat;
         DST_C0:  coef_ff.c0 <= sat;
         DST_C1:  coef_ff.c1 <= sat;
         DST_C2:  coef_ff.c2 <= sat;
         DST_C3:  coef_ff.c3 <= sat;
         default: ;
      endcase
      if (reset) begin
         state_ff <= FETCH;
         cnt_ff   <= 3'd0;
         rv_ff    <= 1'b0;
         dst_ff   <= DST_NONE;
      end else if (start) begin
         state_ff <= FETCH;
         cnt_ff   <= 3'd0;
         rv_ff    <= 1'b0;
         dst_ff   <= DST_NONE;
      end else begin
         dst_ff <= dst_in;
         rv_ff  <= (state_ff == FETCH) && (cnt_ff < 3'd6);
         case (state_ff)
            FETCH: begin
               if (cnt_ff == 3'd6) begin
                  state_ff <= MUL;
                  cnt_ff   <= 3'd0;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            MUL: begin
               if (cnt_ff == 3'd7) begin
                  state_ff <= IDLE;
                  cnt_ff   <= 3'd0;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            default: cnt_ff <= 3'd0;
         endcase
      end
   end

   assign coef = coef_ff;
   assign busy = (state_ff != IDLE);

endmodule

// ===== hw/rtl/rbsp_lane.sv =====
module rbsp_lane #(
   parameter int SPRITE_ROWS   = rbsp_pkg::SPRITE_ROWS_DEF,
   parameter int BYTES_PER_ROW = rbsp_pkg::BYTES_PER_ROW_DEF
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [2:0]            lane_idx,
   input  logic [4:0]            row_index,
   input  logic [1:0]            byte_column,
   input  logic                  pix_bit,
   input  rbsp_pkg::coef_type    coef,
   input  logic signed [11:0]    origin_x,
   input  logic signed [11:0]    origin_y,
   input  logic [12:0]           screen_width,
   input  logic [12:0]           screen_height,
   input  logic [12:0]           row_pitch_words,
   output rbsp_pkg::lane_res_type res
);
   import rbsp_pkg::*;

   logic signed [7:0]  px, py;
   logic               inr;
   logic signed [27:0] sxs_ff, sys_ff;
   logic               hitp_ff;
   lane_res_type       res_ff;
   logic signed [12:0] qx, qy;
   logic               okx, oky;
   logic [24:0]        mul;

   assign px  = $signed({3'b000, byte_column, lane_idx}) - 8'(CENTRE_OFFSET);
   assign py  = $signed({3'b000, row_index}) - 8'(CENTRE_OFFSET);
   assign inr = (32'(row_index) < SPRITE_ROWS) && (32'(byte_column) < BYTES_PER_ROW);

   // truncate toward zero: bump a negative quotient that left a remainder
   always_comb begin
      qx  = sxs_ff[27:15] + 13'((sxs_ff[27] && (sxs_ff[14:0] != 15'd0)) ? 1 : 0);
      qy  = sys_ff[27:15] + 13'((sys_ff[27] && (sys_ff[14:0] != 15'd0)) ? 1 : 0);
      okx = !qx[12] && ({1'b0, qx[11:0]} < screen_width);
      oky = !qy[12] && ({1'b0, qy[11:0]} < screen_height);
      mul = qy[11:0] * row_pitch_words;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sxs_ff     <= 28'(px * coef.c0) + 28'(py * coef.c1) + (28'(origin_x) <<< 15);
         sys_ff     <= 28'(px * coef.c2) + 28'(py * coef.c3) + (28'(origin_y) <<< 15);
         hitp_ff    <= inr && pix_bit;
         res_ff.hit <= hitp_ff && okx && oky;
         res_ff.x   <= qx[11:0];
         res_ff.y   <= qy[11:0];
         res_ff.off <= mul[23:0] + {12'd0, qx[11:0]};
      end
   end

   assign res = res_ff;

endmodule

// ===== hw/rtl/rbsp_merge.sv =====
module rbsp_merge (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         load,
   input  rbsp_pkg::lane_res_type [rbsp_pkg::LANES-1:0] lanes,
   input  logic                                         rsp_stall,
   output logic                                         load_ok,
   output logic                                         rsp_valid,
   output logic [11:0]                                  rsp_pixel_x,
   output logic [11:0]                                  rsp_pixel_y,
   output logic [23:0]                                  rsp_word_offset,
   output logic                                         rsp_last_of_run
);
   import rbsp_pkg::*;

   logic [LANES-1:0]             mask_ff, rest;
   lane_res_type [LANES-1:0]     hold_ff;
   logic [$clog2(LANES)-1:0]     sel;
   logic                         out_free, emit;
   logic                         valid_ff;
   logic [11:0]                  x_ff, y_ff;
   logic [23:0]                  off_ff;
   logic                         last_ff;

   // lowest lane first: lane 0 carries the leftmost pixel
   always_comb begin
      sel = '0;
      for (int i = LANES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = i[$clog2(LANES)-1:0];
         end
      end
      rest     = mask_ff & ~(LANES'(1) << sel);
      out_free = !valid_ff || !rsp_stall;
      emit     = out_free && (mask_ff != '0);
      load_ok  = (mask_ff == '0) || (emit && (rest == '0));
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         x_ff    <= hold_ff[sel].x;
         y_ff    <= hold_ff[sel].y;
         off_ff  <= hold_ff[sel].off;
         last_ff <= (rest == '0);
      end
      if (load) begin
         hold_ff <= lanes;
      end
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            for (int i = 0; i < LANES; i++) begin
               mask_ff[i] <= lanes[i].hit;
            end
         end else if (emit) begin
            mask_ff <= rest;
         end
         if (out_free) begin
            valid_ff <= emit;
         end
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_x     = x_ff;
   assign rsp_pixel_y     = y_ff;
   assign rsp_word_offset = off_ff;
   assign rsp_last_of_run = last_ff;

endmodule

// ===== hw/rtl/rotated_bitmap_sprite_plotter_top.sv =====
// Path: an accepted byte passes both lane stages and the merge hold register before rsp_valid is registered.
// Throughput: one byte per cycle while bytes plot at most one pixel and rsp_stall is low; a byte
//   with several plotted pixels holds the merge stage until it has emitted each of them in turn.
// Reset: synchronous; clears control, loads register defaults, then the coefficient
//   sequencer runs its FETCH and MUL states (also after each angle write) with req_stall high.
module rotated_bitmap_sprite_plotter_top #(
   parameter int SPRITE_ROWS   = rbsp_pkg::SPRITE_ROWS_DEF,
   parameter int BYTES_PER_ROW = rbsp_pkg::BYTES_PER_ROW_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input transactions: one sprite bitmap byte
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_row_index,
   input  logic [1:0]  req_byte_column,
   input  logic [7:0]  req_bitmap_byte,
   // output transactions: one pixel write
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [11:0] rsp_pixel_x,
   output logic [11:0] rsp_pixel_y,
   output logic [23:0] rsp_word_offset,
   output logic [15:0] rsp_pixel_color,
   output logic        rsp_last_of_run,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rbsp_pkg::*;

   logic [11:0]        angle_x_ff, angle_y_ff, angle_z_ff;
   logic signed [11:0] origin_x_ff, origin_y_ff;
   logic [12:0]        width_ff, height_ff, pitch_ff;
   logic               wr;
   logic [2:0]         widx;
   logic               angle_wr;
   coef_type           coef;
   logic               coef_busy;
   logic               en, accept, load_ok;
   logic               v1_ff, v2_ff;
   lane_res_type [LANES-1:0] lane_res;

   // Register writes land on the access phase; pready is tied high.
   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign widx       = csr_paddr[4:2];
   assign angle_wr   = wr && ((widx == REG_ANGLE_X) || (widx == REG_ANGLE_Y)
                              || (widx == REG_ANGLE_Z));

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_x_ff  <= 12'd0;
         angle_y_ff  <= 12'd0;
         angle_z_ff  <= 12'd0;
         origin_x_ff <= 12'sd100;
         origin_y_ff <= 12'sd100;
         width_ff    <= 13'd640;
         height_ff   <= 13'd480;
         pitch_ff    <= 13'd640;
      end else if (wr) begin
         case (widx)
            REG_ANGLE_X:  angle_x_ff  <= csr_pwdata[11:0];
            REG_ANGLE_Y:  angle_y_ff  <= csr_pwdata[11:0];
            REG_ANGLE_Z:  angle_z_ff  <= csr_pwdata[11:0];
            REG_ORIGIN_X: origin_x_ff <= csr_pwdata[11:0];
            REG_ORIGIN_Y: origin_y_ff <= csr_pwdata[11:0];
            REG_WIDTH:    width_ff    <= csr_pwdata[12:0];
            REG_HEIGHT:   height_ff   <= csr_pwdata[12:0];
            REG_PITCH:    pitch_ff    <= csr_pwdata[12:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (widx)
         REG_ANGLE_X:  csr_prdata = {20'd0, angle_x_ff};
         REG_ANGLE_Y:  csr_prdata = {20'd0, angle_y_ff};
         REG_ANGLE_Z:  csr_prdata = {20'd0, angle_z_ff};
         REG_ORIGIN_X: csr_prdata = {20'd0, origin_x_ff};
         REG_ORIGIN_Y: csr_prdata = {20'd0, origin_y_ff};
         REG_WIDTH:    csr_prdata = {19'd0, width_ff};
         REG_HEIGHT:   csr_prdata = {19'd0, height_ff};
         REG_PITCH:    csr_prdata = {19'd0, pitch_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   // Matrix coefficients: one shared 18x18 multiplier, reloaded after reset
   // and after every angle write.
   rbsp_coef u_coef (
      .clock   (clock),
      .reset   (reset),
      .start   (angle_wr),
      .angle_x (angle_x_ff),
      .angle_y (angle_y_ff),
      .angle_z (angle_z_ff),
      .coef    (coef),
      .busy    (coef_busy)
   );

   // The two lane stages advance together whenever the merge stage can take
   // what the second stage holds; hold everything otherwise.
   assign en        = load_ok;
   assign req_stall = !en || coef_busy;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   // One lane per bit of the byte; lane 0 takes the MSB.
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      rbsp_lane #(
         .SPRITE_ROWS   (SPRITE_ROWS),
         .BYTES_PER_ROW (BYTES_PER_ROW)
      ) u_lane (
         .clock           (clock),
         .en              (en),
         .lane_idx        (3'(g)),
         .row_index       (req_row_index),
         .byte_column     (req_byte_column),
         .pix_bit         (accept && req_bitmap_byte[LANES-1-g]),
         .coef            (coef),
         .origin_x        (origin_x_ff),
         .origin_y        (origin_y_ff),
         .screen_width    (width_ff),
         .screen_height   (height_ff),
         .row_pitch_words (pitch_ff),
         .res             (lane_res[g])
      );
   end

   // Merge: drop the clipped lanes, emit the rest one transaction a cycle while rsp_stall is low.
   rbsp_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .load            (en && v2_ff),
      .lanes           (lane_res),
      .rsp_stall       (rsp_stall),
      .load_ok         (load_ok),
      .rsp_valid       (rsp_valid),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_word_offset (rsp_word_offset),
      .rsp_last_of_run (rsp_last_of_run)
   );

   assign rsp_pixel_color = PIXEL_COLOR;

endmodule

// ===== hw/rtl/rbsp_checker.sv =====
`include "rotated_bitmap_sprite_plotter_top_defines.svh"

module rbsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [11:0] rsp_pixel_x,
   input logic [11:0] rsp_pixel_y,
   input logic [23:0] rsp_word_offset,
   input logic [15:0] rsp_pixel_color,
   input logic        rsp_last_of_run,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [4:0]  csr_paddr
);
   import rbsp_pkg::*;

   `RBSP_ASSERT_NEXT_ALWAYS(a_reset_quiet, reset, !rsp_valid && req_stall, "output active or input open after reset")

   `RBSP_ASSERT_NEXT(a_angle_stall, csr_psel && csr_penable && csr_pwrite && ((csr_paddr[4:2] == REG_ANGLE_X) || (csr_paddr[4:2] == REG_ANGLE_Y) || (csr_paddr[4:2] == REG_ANGLE_Z)), req_stall, "input open while coefficients reload")

   `RBSP_ASSERT_NOW(a_color, rsp_valid, rsp_pixel_color == PIXEL_COLOR, "pixel color not white")

   `RBSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word_offset) && $stable(rsp_last_of_run), "stalled pixel write changed")

endmodule

bind rotated_bitmap_sprite_plotter_top rbsp_checker u_rbsp_checker (.*);
